// ===== rtl/gjrnll_pkg.sv =====
// Shared types, constants and the natural-log ROM builder for the GJR-GARCH
// negative log-likelihood block. No dependencies.
package gjrnll_pkg;

    // Fixed-point format of returns, proxies, variance and the running sum.
    localparam int FRAC_BITS     = 24;
    localparam int LN_TABLE_BITS = 10;
    localparam int SEG_BITS      = 30 - LN_TABLE_BITS;
    localparam int LN_ROM_DEPTH  = (1 << LN_TABLE_BITS) + 1;
    localparam int LN_IDX_W      = LN_TABLE_BITS + 1;

    // Split point of the previous variance for the beta product.
    localparam int BETA_SPLIT = 24;

    // Divider widths.
    localparam int DIV_DVD_W = 64;
    localparam int DIV_DSR_W = 48;
    localparam int DIV_CNT_W = 6;

    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;
    localparam logic [47:0] MASK48  = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN64 = 64'shFFFF_8000_0000_0000;

    // Result status codes.
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NONPOS = 2'd1;
    localparam logic [1:0] STATUS_SAT    = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_OMEGA     = 3'd0;
    localparam logic [2:0] REG_ALPHA     = 3'd1;
    localparam logic [2:0] REG_BETA      = 3'd2;
    localparam logic [2:0] REG_GAMMA     = 3'd3;
    localparam logic [2:0] REG_DIST_MODE = 3'd4;
    localparam logic [2:0] REG_T_CONST   = 3'd5;
    localparam logic [2:0] REG_T_WEIGHT  = 3'd6;

    typedef struct packed {
        logic signed [31:0] ret;
        logic [31:0]        proxy;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] neg_loglik;
        logic [1:0]         status;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        omega;
        logic [31:0]        alpha;
        logic [31:0]        beta;
        logic [31:0]        gamma;
        logic               dist_mode;
        logic signed [31:0] t_const;
        logic [31:0]        t_weight;
    } cfg_t;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEED_ZERO,
        OP_DIV_SEED,
        OP_SEED_DONE,
        OP_MUL_A,
        OP_ACC_A,
        OP_MUL_G,
        OP_ACC_G,
        OP_MUL_BH,
        OP_SAVE_BH,
        OP_MUL_BL,
        OP_ACC_B,
        OP_HSAT,
        OP_ZERO_FLAG,
        OP_MUL_R,
        OP_DIV_Q,
        OP_Q_SAVE,
        OP_LN_LOAD_H,
        OP_LN_LOAD_Q,
        OP_NORM,
        OP_ROM,
        OP_MUL_I,
        OP_LN_ADD_I,
        OP_MUL_P,
        OP_LN_ADD_P,
        OP_TERM_H,
        OP_TERM_N,
        OP_MUL_W,
        OP_TERM_T,
        OP_SUM,
        OP_COMMIT
    } dp_op_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic first;
        logic den_pos;
        logic h_zero;
        logic norm_done;
        logic dist_mode;
        logic last;
        logic out_busy;
        logic div_busy;
    } dp_status_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEED_ZERO,
        ST_SEED_DIV,
        ST_SEED_WAIT,
        ST_SEED_DONE,
        ST_MUL_A,
        ST_ACC_A,
        ST_MUL_G,
        ST_ACC_G,
        ST_MUL_BH,
        ST_SAVE_BH,
        ST_MUL_BL,
        ST_ACC_B,
        ST_HSAT,
        ST_CHK_H,
        ST_ZERO_H,
        ST_MUL_R,
        ST_DIV_Q,
        ST_Q_WAIT,
        ST_Q_SAVE,
        ST_LN_LOAD_H,
        ST_LN_NORM,
        ST_LN_ROM,
        ST_LN_MUL_I,
        ST_LN_ADD_I,
        ST_LN_MUL_P,
        ST_LN_ADD_P,
        ST_TERM_H,
        ST_TERM_N,
        ST_LN_LOAD_Q,
        ST_MUL_W,
        ST_TERM_T,
        ST_SUM,
        ST_COMMIT
    } ctrl_state_t;

    typedef logic [29:0] ln_rom_t [LN_ROM_DEPTH];

    // One ROM entry: ln(1 + i/2^L) in Q30, from a bitwise log2 times ln2.
    function automatic logic [29:0] ln_rom_entry(input int unsigned i);
        longint unsigned m;
        longint unsigned f;
        longint unsigned r;
        if (i == (1 << LN_TABLE_BITS)) begin
            return LN2_Q30[29:0];
        end
        m = (64'd1 << 30) + (longint'(i) << SEG_BITS);
        f = 0;
        for (int k = 0; k < 30; k++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd1 << 31)) begin
                f = f | 64'd1;
                m = m >> 1;
            end
        end
        r = (f * LN2_Q32 + (64'd1 << 31)) >> 32;
        return r[29:0];
    endfunction

    function automatic ln_rom_t build_ln_rom();
        ln_rom_t t;
        for (int i = 0; i < LN_ROM_DEPTH; i++) begin
            t[i] = ln_rom_entry(i);
        end
        return t;
    endfunction

endpackage

// ===== rtl/gjrnll_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gjrnll_pkg for its widths.
module gjrnll_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [gjrnll_pkg::DIV_DVD_W-1:0]     dividend,
    input  logic [gjrnll_pkg::DIV_DSR_W-1:0]     divisor,
    output logic                                 busy,
    output logic [gjrnll_pkg::DIV_DVD_W-1:0]     quotient
);

    logic                                 busy_reg, busy_next;
    logic [gjrnll_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [gjrnll_pkg::DIV_DVD_W-1:0]     dvd_reg, dvd_next;
    logic [gjrnll_pkg::DIV_DSR_W-1:0]     dsr_reg, dsr_next;
    logic [gjrnll_pkg::DIV_DSR_W-1:0]     rem_reg, rem_next;
    logic [gjrnll_pkg::DIV_DSR_W:0]       trial;
    logic                                 qbit;

    // Shift one dividend bit into the partial remainder and try a subtract.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[gjrnll_pkg::DIV_DVD_W-1]};
        qbit  = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = qbit ? gjrnll_pkg::DIV_DSR_W'(trial - {1'b0, dsr_reg})
                            : trial[gjrnll_pkg::DIV_DSR_W-1:0];
            dvd_next = {dvd_reg[gjrnll_pkg::DIV_DVD_W-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/gjrnll_dp.sv =====
// Datapath: series state, shared 32x32 multiplier, log ROM and divider,
// and the output register. Depends on gjrnll_pkg and gjrnll_div.
module gjrnll_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gjrnll_pkg::cfg_t        cfg,
    input  gjrnll_pkg::in_item_t    in_data,
    input  gjrnll_pkg::dp_op_t      op,
    output gjrnll_pkg::dp_status_t  status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output gjrnll_pkg::out_item_t   out_data
);

    localparam int F = gjrnll_pkg::FRAC_BITS;
    localparam int L = gjrnll_pkg::LN_TABLE_BITS;
    localparam int S = gjrnll_pkg::SEG_BITS;
    localparam gjrnll_pkg::ln_rom_t LN_ROM = gjrnll_pkg::build_ln_rom();

    // Series state.
    logic [47:0]          prev_var_reg, prev_var_next;
    logic [31:0]          prev_ret_reg, prev_ret_next;
    logic [31:0]          prev_proxy_reg, prev_proxy_next;
    logic signed [47:0]   sum_reg, sum_next;
    logic                 first_reg, first_next;
    logic [1:0]           err_reg, err_next;
    logic                 out_valid_reg, out_valid_next;

    // Working registers.
    gjrnll_pkg::in_item_t  item_reg, item_next;
    gjrnll_pkg::out_item_t out_reg, out_next;
    logic [63:0]          prod_reg, prod_next;
    logic [63:0]          p1_reg, p1_next;
    logic [50:0]          h_reg, h_next;
    logic [63:0]          q_reg, q_next;
    logic [63:0]          x_reg, x_next;
    logic [5:0]           sh_reg, sh_next;
    logic signed [39:0]   ln_v_reg, ln_v_next;
    logic signed [63:0]   term_reg, term_next;
    logic [29:0]          t0_reg, t1_reg;

    // Combinational helpers.
    logic signed [35:0]   den;
    logic [31:0]          mul_a, mul_b;
    logic                 mul_en;
    logic [31:0]          ar;
    logic [87:0]          acc_b_wide;
    logic signed [7:0]    pf;
    logic [7:0]           pf_mag;
    logic signed [39:0]   lu;
    logic signed [39:0]   lnh_half;
    logic signed [63:0]   sum_wide;
    logic [L-1:0]         rom_idx;
    logic [L:0]           rom_idx_p1;
    logic [S-1:0]         rom_rem;
    logic                 div_start;
    logic [63:0]          div_dvd;
    logic [47:0]          div_dsr;
    logic                 div_busy;
    logic [63:0]          quot;
    logic [1:0]           raise_code;

    gjrnll_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (quot)
    );

    // Seed denominator 2^31 - 2*alpha - 2*beta - gamma.
    assign den = $signed({4'b0, 32'h8000_0000}) - $signed({3'b0, cfg.alpha, 1'b0})
               - $signed({3'b0, cfg.beta, 1'b0}) - $signed({4'b0, cfg.gamma});

    assign ar         = item_reg.ret[31] ? (~item_reg.ret + 32'd1) : item_reg.ret;
    assign acc_b_wide = {p1_reg, 24'b0} + {24'b0, prod_reg};
    assign pf         = 8'sd63 - $signed({2'b0, sh_reg}) - 8'(F);
    assign pf_mag     = pf[7] ? 8'(-pf) : pf;
    assign lu         = ln_v_reg >>> (30 - F);
    assign lnh_half   = ln_v_reg >>> (31 - F);
    assign sum_wide   = {{16{sum_reg[47]}}, sum_reg} + term_reg;

    // Mantissa of the normalized log argument: table index and remainder.
    assign rom_idx    = x_reg[62 -: L];
    assign rom_idx_p1 = {1'b0, rom_idx} + 1'b1;
    assign rom_rem    = x_reg[62-L -: S];

    // Divider operands.
    assign div_start = (op == gjrnll_pkg::OP_DIV_SEED) || (op == gjrnll_pkg::OP_DIV_Q);
    assign div_dvd   = (op == gjrnll_pkg::OP_DIV_Q) ? prod_reg
                                                    : (64'(cfg.omega) << (F + 1));
    assign div_dsr   = (op == gjrnll_pkg::OP_DIV_Q) ? h_reg[47:0] : {16'b0, den[31:0]};

    // Multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (op)
            gjrnll_pkg::OP_MUL_A:
            begin
                mul_a = cfg.alpha;
                mul_b = prev_proxy_reg;
            end
            gjrnll_pkg::OP_MUL_G:
            begin
                mul_a = cfg.gamma;
                mul_b = prev_proxy_reg;
            end
            gjrnll_pkg::OP_MUL_BH:
            begin
                mul_a = cfg.beta;
                mul_b = 32'(prev_var_reg[47:gjrnll_pkg::BETA_SPLIT]);
            end
            gjrnll_pkg::OP_MUL_BL:
            begin
                mul_a = cfg.beta;
                mul_b = 32'(prev_var_reg[gjrnll_pkg::BETA_SPLIT-1:0]);
            end
            gjrnll_pkg::OP_MUL_R:
            begin
                mul_a = ar;
                mul_b = ar;
            end
            gjrnll_pkg::OP_MUL_I:
            begin
                mul_a = 32'(t1_reg - t0_reg);
                mul_b = 32'(rom_rem);
            end
            gjrnll_pkg::OP_MUL_P:
            begin
                mul_a = 32'(pf_mag);
                mul_b = gjrnll_pkg::LN2_Q30;
            end
            gjrnll_pkg::OP_MUL_W:
            begin
                mul_a = cfg.t_weight;
                mul_b = lu[31:0];
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Datapath register updates for each command.
    always_comb
    begin
        prev_var_next   = prev_var_reg;
        prev_ret_next   = prev_ret_reg;
        prev_proxy_next = prev_proxy_reg;
        sum_next        = sum_reg;
        first_next      = first_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        item_next       = item_reg;
        out_next        = out_reg;
        prod_next       = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_reg;
        p1_next         = p1_reg;
        h_next          = h_reg;
        q_next          = q_reg;
        x_next          = x_reg;
        sh_next         = sh_reg;
        ln_v_next       = ln_v_reg;
        term_next       = term_reg;
        raise_code      = gjrnll_pkg::STATUS_OK;

        case (op)
            gjrnll_pkg::OP_LOAD:
            begin
                item_next = in_data;
            end
            gjrnll_pkg::OP_SEED_ZERO:
            begin
                h_next     = '0;
                first_next = 1'b0;
                raise_code = gjrnll_pkg::STATUS_NONPOS;
            end
            gjrnll_pkg::OP_SEED_DONE:
            begin
                first_next = 1'b0;
                if (quot > 64'(gjrnll_pkg::MASK48)) begin
                    h_next     = 51'(gjrnll_pkg::MASK48);
                    raise_code = gjrnll_pkg::STATUS_SAT;
                end else begin
                    h_next = 51'(quot);
                end
            end
            gjrnll_pkg::OP_MUL_A:
            begin
                h_next = 51'(cfg.omega >> (30 - F));
            end
            gjrnll_pkg::OP_ACC_A:
            begin
                h_next = h_reg + 51'(prod_reg >> 30);
            end
            gjrnll_pkg::OP_ACC_G:
            begin
                if (prev_ret_reg[31]) begin
                    h_next = h_reg + 51'(prod_reg >> 30);
                end
            end
            gjrnll_pkg::OP_SAVE_BH:
            begin
                p1_next = prod_reg;
            end
            gjrnll_pkg::OP_ACC_B:
            begin
                h_next = h_reg + 51'(acc_b_wide >> 30);
            end
            gjrnll_pkg::OP_HSAT:
            begin
                if (h_reg > 51'(gjrnll_pkg::MASK48)) begin
                    h_next     = 51'(gjrnll_pkg::MASK48);
                    raise_code = gjrnll_pkg::STATUS_SAT;
                end
            end
            gjrnll_pkg::OP_ZERO_FLAG:
            begin
                raise_code = gjrnll_pkg::STATUS_NONPOS;
            end
            gjrnll_pkg::OP_Q_SAVE:
            begin
                q_next = quot;
            end
            gjrnll_pkg::OP_LN_LOAD_H:
            begin
                x_next  = 64'(h_reg[47:0]);
                sh_next = '0;
            end
            gjrnll_pkg::OP_LN_LOAD_Q:
            begin
                x_next  = q_reg + (64'd1 << F);
                sh_next = '0;
            end
            gjrnll_pkg::OP_NORM:
            begin
                // Coarse-to-fine left shift until the leading one reaches the top.
                if (x_reg[63:48] == '0) begin
                    x_next  = x_reg << 16;
                    sh_next = sh_reg + 6'd16;
                end else if (x_reg[63:60] == '0) begin
                    x_next  = x_reg << 4;
                    sh_next = sh_reg + 6'd4;
                end else if (!x_reg[63]) begin
                    x_next  = x_reg << 1;
                    sh_next = sh_reg + 6'd1;
                end
            end
            gjrnll_pkg::OP_LN_ADD_I:
            begin
                ln_v_next = $signed(40'(t0_reg)) + $signed(40'(prod_reg >> S));
            end
            gjrnll_pkg::OP_LN_ADD_P:
            begin
                if (pf[7]) begin
                    ln_v_next = ln_v_reg - $signed(40'(prod_reg));
                end else begin
                    ln_v_next = ln_v_reg + $signed(40'(prod_reg));
                end
            end
            gjrnll_pkg::OP_TERM_H:
            begin
                term_next = {{24{lnh_half[39]}}, lnh_half};
            end
            gjrnll_pkg::OP_TERM_N:
            begin
                term_next = term_reg + $signed({1'b0, q_reg[63:1]});
            end
            gjrnll_pkg::OP_TERM_T:
            begin
                term_next = term_reg + $signed(prod_reg >> F)
                          - $signed({{32{cfg.t_const[31]}}, cfg.t_const});
            end
            gjrnll_pkg::OP_SUM:
            begin
                if (sum_wide > gjrnll_pkg::SUM_MAX64) begin
                    sum_next   = gjrnll_pkg::SUM_MAX64[47:0];
                    raise_code = gjrnll_pkg::STATUS_SAT;
                end else if (sum_wide < gjrnll_pkg::SUM_MIN64) begin
                    sum_next   = gjrnll_pkg::SUM_MIN64[47:0];
                    raise_code = gjrnll_pkg::STATUS_SAT;
                end else begin
                    sum_next = sum_wide[47:0];
                end
            end
            gjrnll_pkg::OP_COMMIT:
            begin
                prev_var_next   = h_reg[47:0];
                prev_ret_next   = item_reg.ret;
                prev_proxy_next = item_reg.proxy;
                // The last sample of a series emits the sum and restarts.
                if (item_reg.last) begin
                    out_next.neg_loglik = sum_reg;
                    out_next.status     = err_reg;
                    out_valid_next      = 1'b1;
                    prev_var_next       = '0;
                    prev_ret_next       = '0;
                    prev_proxy_next     = '0;
                    sum_next            = '0;
                    first_next          = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Status keeps the first error code of the series.
        if ((raise_code != gjrnll_pkg::STATUS_OK) && (err_reg == gjrnll_pkg::STATUS_OK)) begin
            err_next = raise_code;
        end
        if ((op == gjrnll_pkg::OP_COMMIT) && item_reg.last) begin
            err_next = gjrnll_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prev_var_reg   <= '0;
            prev_ret_reg   <= '0;
            prev_proxy_reg <= '0;
            sum_reg        <= '0;
            first_reg      <= 1'b1;
            err_reg        <= gjrnll_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
        end else begin
            prev_var_reg   <= prev_var_next;
            prev_ret_reg   <= prev_ret_next;
            prev_proxy_reg <= prev_proxy_next;
            sum_reg        <= sum_next;
            first_reg      <= first_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
        prod_reg <= prod_next;
        p1_reg   <= p1_next;
        h_reg    <= h_next;
        q_reg    <= q_next;
        x_reg    <= x_next;
        sh_reg   <= sh_next;
        ln_v_reg <= ln_v_next;
        term_reg <= term_next;
    end

    // Log ROM with registered reads of two neighboring entries.
    always_ff @(posedge clk)
    begin
        if (op == gjrnll_pkg::OP_ROM) begin
            t0_reg <= LN_ROM[{1'b0, rom_idx}];
            t1_reg <= LN_ROM[rom_idx_p1];
        end
    end

    always_comb
    begin
        status.first     = first_reg;
        status.den_pos   = (den > 36'sd0);
        status.h_zero    = (h_reg == '0);
        status.norm_done = x_reg[63];
        status.dist_mode = cfg.dist_mode;
        status.last      = item_reg.last;
        status.out_busy  = out_valid_reg;
        status.div_busy  = div_busy;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/gjrnll_ctrl.sv =====
// Controller state machine that sequences the datapath commands per sample.
// Depends on gjrnll_pkg.
module gjrnll_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  gjrnll_pkg::dp_status_t  status,
    output gjrnll_pkg::dp_op_t      op
);

    gjrnll_pkg::ctrl_state_t state_reg, state_next;
    logic                    ln_sel_reg, ln_sel_next;

    // Next-state logic.
    always_comb
    begin
        state_next  = state_reg;
        ln_sel_next = ln_sel_reg;
        case (state_reg)
            gjrnll_pkg::ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = gjrnll_pkg::ST_DISPATCH;
                end
            end
            gjrnll_pkg::ST_DISPATCH:
            begin
                if (!status.first) begin
                    state_next = gjrnll_pkg::ST_MUL_A;
                end else if (status.den_pos) begin
                    state_next = gjrnll_pkg::ST_SEED_DIV;
                end else begin
                    state_next = gjrnll_pkg::ST_SEED_ZERO;
                end
            end
            gjrnll_pkg::ST_SEED_ZERO: state_next = gjrnll_pkg::ST_COMMIT;
            gjrnll_pkg::ST_SEED_DIV:  state_next = gjrnll_pkg::ST_SEED_WAIT;
            gjrnll_pkg::ST_SEED_WAIT:
            begin
                if (!status.div_busy) begin
                    state_next = gjrnll_pkg::ST_SEED_DONE;
                end
            end
            gjrnll_pkg::ST_SEED_DONE: state_next = gjrnll_pkg::ST_COMMIT;
            gjrnll_pkg::ST_MUL_A:     state_next = gjrnll_pkg::ST_ACC_A;
            gjrnll_pkg::ST_ACC_A:     state_next = gjrnll_pkg::ST_MUL_G;
            gjrnll_pkg::ST_MUL_G:     state_next = gjrnll_pkg::ST_ACC_G;
            gjrnll_pkg::ST_ACC_G:     state_next = gjrnll_pkg::ST_MUL_BH;
            gjrnll_pkg::ST_MUL_BH:    state_next = gjrnll_pkg::ST_SAVE_BH;
            gjrnll_pkg::ST_SAVE_BH:   state_next = gjrnll_pkg::ST_MUL_BL;
            gjrnll_pkg::ST_MUL_BL:    state_next = gjrnll_pkg::ST_ACC_B;
            gjrnll_pkg::ST_ACC_B:     state_next = gjrnll_pkg::ST_HSAT;
            gjrnll_pkg::ST_HSAT:      state_next = gjrnll_pkg::ST_CHK_H;
            gjrnll_pkg::ST_CHK_H:
            begin
                if (status.h_zero) begin
                    state_next = gjrnll_pkg::ST_ZERO_H;
                end else begin
                    state_next = gjrnll_pkg::ST_MUL_R;
                end
            end
            gjrnll_pkg::ST_ZERO_H:    state_next = gjrnll_pkg::ST_COMMIT;
            gjrnll_pkg::ST_MUL_R:     state_next = gjrnll_pkg::ST_DIV_Q;
            gjrnll_pkg::ST_DIV_Q:     state_next = gjrnll_pkg::ST_Q_WAIT;
            gjrnll_pkg::ST_Q_WAIT:
            begin
                if (!status.div_busy) begin
                    state_next = gjrnll_pkg::ST_Q_SAVE;
                end
            end
            gjrnll_pkg::ST_Q_SAVE:    state_next = gjrnll_pkg::ST_LN_LOAD_H;
            gjrnll_pkg::ST_LN_LOAD_H:
            begin
                ln_sel_next = 1'b0;
                state_next  = gjrnll_pkg::ST_LN_NORM;
            end
            gjrnll_pkg::ST_LN_NORM:
            begin
                if (status.norm_done) begin
                    state_next = gjrnll_pkg::ST_LN_ROM;
                end
            end
            gjrnll_pkg::ST_LN_ROM:    state_next = gjrnll_pkg::ST_LN_MUL_I;
            gjrnll_pkg::ST_LN_MUL_I:  state_next = gjrnll_pkg::ST_LN_ADD_I;
            gjrnll_pkg::ST_LN_ADD_I:  state_next = gjrnll_pkg::ST_LN_MUL_P;
            gjrnll_pkg::ST_LN_MUL_P:  state_next = gjrnll_pkg::ST_LN_ADD_P;
            gjrnll_pkg::ST_LN_ADD_P:
            begin
                if (ln_sel_reg) begin
                    state_next = gjrnll_pkg::ST_MUL_W;
                end else begin
                    state_next = gjrnll_pkg::ST_TERM_H;
                end
            end
            gjrnll_pkg::ST_TERM_H:
            begin
                if (status.dist_mode) begin
                    state_next = gjrnll_pkg::ST_LN_LOAD_Q;
                end else begin
                    state_next = gjrnll_pkg::ST_TERM_N;
                end
            end
            gjrnll_pkg::ST_TERM_N:    state_next = gjrnll_pkg::ST_SUM;
            gjrnll_pkg::ST_LN_LOAD_Q:
            begin
                ln_sel_next = 1'b1;
                state_next  = gjrnll_pkg::ST_LN_NORM;
            end
            gjrnll_pkg::ST_MUL_W:     state_next = gjrnll_pkg::ST_TERM_T;
            gjrnll_pkg::ST_TERM_T:    state_next = gjrnll_pkg::ST_SUM;
            gjrnll_pkg::ST_SUM:       state_next = gjrnll_pkg::ST_COMMIT;
            gjrnll_pkg::ST_COMMIT:
            begin
                // Hold a final sample until the output register is free.
                if (!(status.last && status.out_busy)) begin
                    state_next = gjrnll_pkg::ST_IDLE;
                end
            end
            default:                  state_next = gjrnll_pkg::ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        in_ready = 1'b0;
        op       = gjrnll_pkg::OP_NONE;
        case (state_reg)
            gjrnll_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op = gjrnll_pkg::OP_LOAD;
                end
            end
            gjrnll_pkg::ST_SEED_ZERO: op = gjrnll_pkg::OP_SEED_ZERO;
            gjrnll_pkg::ST_SEED_DIV:  op = gjrnll_pkg::OP_DIV_SEED;
            gjrnll_pkg::ST_SEED_DONE: op = gjrnll_pkg::OP_SEED_DONE;
            gjrnll_pkg::ST_MUL_A:     op = gjrnll_pkg::OP_MUL_A;
            gjrnll_pkg::ST_ACC_A:     op = gjrnll_pkg::OP_ACC_A;
            gjrnll_pkg::ST_MUL_G:     op = gjrnll_pkg::OP_MUL_G;
            gjrnll_pkg::ST_ACC_G:     op = gjrnll_pkg::OP_ACC_G;
            gjrnll_pkg::ST_MUL_BH:    op = gjrnll_pkg::OP_MUL_BH;
            gjrnll_pkg::ST_SAVE_BH:   op = gjrnll_pkg::OP_SAVE_BH;
            gjrnll_pkg::ST_MUL_BL:    op = gjrnll_pkg::OP_MUL_BL;
            gjrnll_pkg::ST_ACC_B:     op = gjrnll_pkg::OP_ACC_B;
            gjrnll_pkg::ST_HSAT:      op = gjrnll_pkg::OP_HSAT;
            gjrnll_pkg::ST_ZERO_H:    op = gjrnll_pkg::OP_ZERO_FLAG;
            gjrnll_pkg::ST_MUL_R:     op = gjrnll_pkg::OP_MUL_R;
            gjrnll_pkg::ST_DIV_Q:     op = gjrnll_pkg::OP_DIV_Q;
            gjrnll_pkg::ST_Q_SAVE:    op = gjrnll_pkg::OP_Q_SAVE;
            gjrnll_pkg::ST_LN_LOAD_H: op = gjrnll_pkg::OP_LN_LOAD_H;
            gjrnll_pkg::ST_LN_NORM:
            begin
                if (!status.norm_done) begin
                    op = gjrnll_pkg::OP_NORM;
                end
            end
            gjrnll_pkg::ST_LN_ROM:    op = gjrnll_pkg::OP_ROM;
            gjrnll_pkg::ST_LN_MUL_I:  op = gjrnll_pkg::OP_MUL_I;
            gjrnll_pkg::ST_LN_ADD_I:  op = gjrnll_pkg::OP_LN_ADD_I;
            gjrnll_pkg::ST_LN_MUL_P:  op = gjrnll_pkg::OP_MUL_P;
            gjrnll_pkg::ST_LN_ADD_P:  op = gjrnll_pkg::OP_LN_ADD_P;
            gjrnll_pkg::ST_TERM_H:    op = gjrnll_pkg::OP_TERM_H;
            gjrnll_pkg::ST_TERM_N:    op = gjrnll_pkg::OP_TERM_N;
            gjrnll_pkg::ST_LN_LOAD_Q: op = gjrnll_pkg::OP_LN_LOAD_Q;
            gjrnll_pkg::ST_MUL_W:     op = gjrnll_pkg::OP_MUL_W;
            gjrnll_pkg::ST_TERM_T:    op = gjrnll_pkg::OP_TERM_T;
            gjrnll_pkg::ST_SUM:       op = gjrnll_pkg::OP_SUM;
            gjrnll_pkg::ST_COMMIT:
            begin
                if (!(status.last && status.out_busy)) begin
                    op = gjrnll_pkg::OP_COMMIT;
                end
            end
            default:                  op = gjrnll_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= gjrnll_pkg::ST_IDLE;
            ln_sel_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ln_sel_reg <= ln_sel_next;
        end
    end

endmodule

// ===== rtl/gjr_garch_neg_log_likelihood_top.sv =====
// Top level of the GJR-GARCH negative log-likelihood accumulator: register
// file on the APB-style port, controller and datapath.
// Depends on gjrnll_pkg, gjrnll_ctrl and gjrnll_dp.
//
//   channel   direction  handshake            payload
//   in        request    in_valid / in_ready  in_data  (ret, proxy, last)
//   out       result     out_valid/out_ready  out_data (neg_loglik, status)
//   config    write/read psel,penable,pready  paddr, pwdata, prdata
//
// One sample at a time. The first sample of a series runs the 64-step seed
// division. Later samples run the 64-step divider for r^2/h plus one table
// log evaluation on the shared multiplier with the normal density, or two
// with Student-t. Reset is asynchronous and clears the series state.
// A result waits in the output register while the next sample is taken;
// a final sample stalls only if the previous result is still waiting.
module gjr_garch_neg_log_likelihood_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gjrnll_pkg::in_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output gjrnll_pkg::out_item_t  out_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [4:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    gjrnll_pkg::cfg_t       cfg_reg, cfg_next;
    gjrnll_pkg::dp_op_t     op;
    gjrnll_pkg::dp_status_t status;
    logic                   wr_en;
    logic [2:0]             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                gjrnll_pkg::REG_OMEGA:     cfg_next.omega     = pwdata;
                gjrnll_pkg::REG_ALPHA:     cfg_next.alpha     = pwdata;
                gjrnll_pkg::REG_BETA:      cfg_next.beta      = pwdata;
                gjrnll_pkg::REG_GAMMA:     cfg_next.gamma     = pwdata;
                gjrnll_pkg::REG_DIST_MODE: cfg_next.dist_mode = pwdata[0];
                gjrnll_pkg::REG_T_CONST:   cfg_next.t_const   = pwdata;
                gjrnll_pkg::REG_T_WEIGHT:  cfg_next.t_weight  = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads.
    always_comb
    begin
        case (reg_idx)
            gjrnll_pkg::REG_OMEGA:     prdata = cfg_reg.omega;
            gjrnll_pkg::REG_ALPHA:     prdata = cfg_reg.alpha;
            gjrnll_pkg::REG_BETA:      prdata = cfg_reg.beta;
            gjrnll_pkg::REG_GAMMA:     prdata = cfg_reg.gamma;
            gjrnll_pkg::REG_DIST_MODE: prdata = {31'b0, cfg_reg.dist_mode};
            gjrnll_pkg::REG_T_CONST:   prdata = cfg_reg.t_const;
            gjrnll_pkg::REG_T_WEIGHT:  prdata = cfg_reg.t_weight;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gjrnll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    gjrnll_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .op        (op),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/tb_gjr_garch_neg_log_likelihood_top.sv =====
// Testbench for the GJR-GARCH negative log-likelihood block: directed table, then
// random series under changing parameters, checked against an in-bench predictor.
// Depends on gjrnll_pkg and gjr_garch_neg_log_likelihood_top.
`timescale 1ns / 1ps

module tb_gjr_garch_neg_log_likelihood_top;

    localparam int  CLK_HALF     = 4;
    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  RANDOM_ITEMS = 950;
    localparam int  QUIET_ITEMS  = 120;
    localparam int  DRAIN_CYCLES = 200;
    localparam longint unsigned H_MAX = 64'hFFFF_FFFF_FFFF;
    localparam longint SUM_TOP = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_BOT = 64'shFFFF_8000_0000_0000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    gjrnll_pkg::in_item_t  in_data;
    logic                  out_valid;
    logic                  out_ready;
    gjrnll_pkg::out_item_t out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [4:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    gjr_garch_neg_log_likelihood_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Predictor copy of registers and series state.
    gjrnll_pkg::cfg_t model_cfg;
    longint unsigned  var_prev;
    logic [31:0]      ret_prev;
    logic [31:0]      proxy_prev;
    longint           nll_sum;
    bit               series_start;
    logic [1:0]       series_status;
    logic [31:0]      log_tab [0:gjrnll_pkg::LN_ROM_DEPTH-1];

    gjrnll_pkg::out_item_t expected_totals[$];
    int        fail_count;
    bit        quiet;
    int        long_hold_req;
    int        cycle_count;

    // Directed table.
    typedef struct {
        int                    cfg_set;
        gjrnll_pkg::in_item_t  req;
        bit                    typed;
        gjrnll_pkg::out_item_t result;
    } row_t;
    row_t rows[$];

    always #(CLK_HALF) clk = ~clk;

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Log table: ln(1 + i/2^L) in Q30 from a bitwise log2 times ln2.
    task automatic fill_log_tab();
        longint unsigned m;
        longint unsigned f;
        for (int i = 0; i < (1 << gjrnll_pkg::LN_TABLE_BITS); i++)
        begin
            m = (64'd1 << 30) + (longint'(i) << gjrnll_pkg::SEG_BITS);
            f = 0;
            for (int k = 0; k < 30; k++)
            begin
                m = (m * m) >> 30;
                f = f << 1;
                if (m >= (64'd1 << 31))
                begin
                    f = f | 1;
                    m = m >> 1;
                end
            end
            log_tab[i] = 32'((f * 64'd2977044472 + (64'd1 << 31)) >> 32);
        end
        log_tab[1 << gjrnll_pkg::LN_TABLE_BITS] = 32'd744261118;
    endtask

    // Natural log of a positive Q.24 value, result in Q.24 (floored).
    function automatic longint ln_q24(longint unsigned x);
        int              p;
        longint unsigned n;
        longint unsigned frac;
        longint unsigned rem;
        longint unsigned t0;
        longint unsigned t1;
        int              idx;
        longint          v;
        p = 63;
        while (p > 0 && x[p] == 1'b0)
            p--;
        n = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
        frac = n - (64'd1 << 30);
        idx = int'((frac >> gjrnll_pkg::SEG_BITS) & ((1 << gjrnll_pkg::LN_TABLE_BITS) - 1));
        rem = frac & ((64'd1 << gjrnll_pkg::SEG_BITS) - 1);
        t0 = log_tab[idx];
        t1 = log_tab[idx + 1];
        v = longint'(t0) + longint'(((t1 - t0) * rem) >> gjrnll_pkg::SEG_BITS);
        v = v + longint'(p - gjrnll_pkg::FRAC_BITS) * 64'sd744261118;
        return v >>> (30 - gjrnll_pkg::FRAC_BITS);
    endfunction

    // floor(c * x / 2^30) for a Q2.30 coefficient.
    function automatic longint unsigned coef_mul(logic [31:0] c, longint unsigned x);
        logic [127:0] prod;
        prod = 128'(c) * 128'(x);
        return 64'(prod >> 30);
    endfunction

    function automatic void clear_series();
        var_prev      = 0;
        ret_prev      = 0;
        proxy_prev    = 0;
        nll_sum       = 0;
        series_start  = 1'b1;
        series_status = gjrnll_pkg::STATUS_OK;
    endfunction

    function automatic void flag_status(logic [1:0] code);
        if (series_status == gjrnll_pkg::STATUS_OK)
            series_status = code;
    endfunction

    // Advance the predictor by one request; returns 1 with the total on a final sample.
    function automatic bit predict_sample(gjrnll_pkg::in_item_t req,
                                          output gjrnll_pkg::out_item_t total);
        longint          den;
        longint unsigned h;
        longint unsigned ar;
        longint unsigned q;
        longint unsigned lu;
        longint          term;
        longint          s;
        logic [127:0]    wprod;
        if (series_start)
        begin
            den = (64'sd1 <<< 31) - 2 * longint'(model_cfg.alpha)
                - 2 * longint'(model_cfg.beta) - longint'(model_cfg.gamma);
            if (den <= 0)
            begin
                h = 0;
                flag_status(gjrnll_pkg::STATUS_NONPOS);
            end
            else
            begin
                h = (longint'(model_cfg.omega) << (gjrnll_pkg::FRAC_BITS + 1))
                  / longint'(den);
                if (h > H_MAX)
                begin
                    h = H_MAX;
                    flag_status(gjrnll_pkg::STATUS_SAT);
                end
            end
            series_start = 1'b0;
        end
        else
        begin
            h = (longint'(model_cfg.omega) >> (30 - gjrnll_pkg::FRAC_BITS))
              + ((longint'(model_cfg.alpha) * longint'(proxy_prev)) >> 30)
              + coef_mul(model_cfg.beta, var_prev);
            // Leverage term after a negative return.
            if (ret_prev[31])
                h = h + ((longint'(model_cfg.gamma) * longint'(proxy_prev)) >> 30);
            if (h > H_MAX)
            begin
                h = H_MAX;
                flag_status(gjrnll_pkg::STATUS_SAT);
            end
            if (h == 0)
            begin
                flag_status(gjrnll_pkg::STATUS_NONPOS);
            end
            else
            begin
                ar = (req.ret < 0) ? longint'(-longint'(req.ret)) : longint'(req.ret);
                q = (ar * ar) / h;
                term = ln_q24(h) >>> 1;
                if (model_cfg.dist_mode)
                begin
                    lu = longint'(ln_q24(q + (64'd1 << gjrnll_pkg::FRAC_BITS)));
                    wprod = 128'(model_cfg.t_weight) * 128'(lu);
                    term = term + longint'(wprod >> gjrnll_pkg::FRAC_BITS)
                         - longint'(model_cfg.t_const);
                end
                else
                begin
                    term = term + longint'(q >> 1);
                end
                s = nll_sum + term;
                if (s > SUM_TOP)
                begin
                    s = SUM_TOP;
                    flag_status(gjrnll_pkg::STATUS_SAT);
                end
                if (s < SUM_BOT)
                begin
                    s = SUM_BOT;
                    flag_status(gjrnll_pkg::STATUS_SAT);
                end
                nll_sum = s;
            end
        end
        var_prev   = h;
        ret_prev   = req.ret;
        proxy_prev = req.proxy;
        total.neg_loglik = nll_sum[47:0];
        total.status     = series_status;
        if (req.last)
        begin
            clear_series();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One register write: setup cycle, then access cycle.
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_params(gjrnll_pkg::cfg_t c);
        reg_write(gjrnll_pkg::REG_OMEGA, c.omega);
        reg_write(gjrnll_pkg::REG_ALPHA, c.alpha);
        reg_write(gjrnll_pkg::REG_BETA, c.beta);
        reg_write(gjrnll_pkg::REG_GAMMA, c.gamma);
        reg_write(gjrnll_pkg::REG_DIST_MODE, {31'd0, c.dist_mode});
        reg_write(gjrnll_pkg::REG_T_CONST, c.t_const);
        reg_write(gjrnll_pkg::REG_T_WEIGHT, c.t_weight);
        model_cfg = c;
    endtask

    // Wait for all totals, then for any sample still in flight.
    task automatic wait_idle();
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one request and hold it until accepted; optionally expect a given total.
    task automatic send_sample(gjrnll_pkg::in_item_t req, bit typed,
                               gjrnll_pkg::out_item_t typed_total);
        gjrnll_pkg::out_item_t total;
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_sample(req, total))
            expected_totals.push_back(typed ? typed_total : total);
        if (!quiet && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
    endtask

    function automatic gjrnll_pkg::cfg_t random_params();
        gjrnll_pkg::cfg_t c;
        if ($urandom_range(5) == 0)
        begin
            c.omega = $urandom;
            c.alpha = $urandom;
            c.beta  = $urandom;
            c.gamma = $urandom;
        end
        else
        begin
            c.omega = $urandom_range(32'h1000_0000);
            c.alpha = $urandom_range(32'h0800_0000);
            c.beta  = $urandom_range(32'h3C00_0000, 32'h1000_0000);
            c.gamma = $urandom_range(32'h0800_0000);
        end
        c.dist_mode = $urandom_range(1);
        c.t_const   = $urandom;
        c.t_weight  = ($urandom_range(1)) ? $urandom
                                          : $urandom_range(32'h0A00_0000, 32'h0100_0000);
        return c;
    endfunction

    function automatic gjrnll_pkg::in_item_t random_sample(bit last);
        gjrnll_pkg::in_item_t r;
        r.ret   = ($urandom_range(7) == 0) ? $urandom
                : $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
        r.proxy = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0400_0000);
        r.last  = last;
        return r;
    endfunction

    function automatic void add_row(int cfg_set, logic [31:0] ret, logic [31:0] proxy, bit last,
                                    bit typed, logic [47:0] nll, logic [1:0] status);
        row_t r;
        r.cfg_set = cfg_set;
        r.req.ret = ret;
        r.req.proxy = proxy;
        r.req.last = last;
        r.typed = typed;
        r.result.neg_loglik = nll;
        r.result.status = status;
        rows.push_back(r);
    endfunction

    function automatic gjrnll_pkg::cfg_t param_set(int n);
        gjrnll_pkg::cfg_t c;
        c = '0;
        case (n)
            1: c = '{omega: '1, alpha: '1, beta: '1, gamma: '1, dist_mode: 1'b1,
                     t_const: '1, t_weight: '1};
            2: c = '{omega: '1, alpha: 32'h3FFF_FFFF, beta: '0, gamma: '0, dist_mode: 1'b0,
                     t_const: 32'sh7FFF_FFFF, t_weight: '0};
            3: c = '{omega: 32'h0010_0000, alpha: 32'h0666_6666, beta: 32'h3333_3333,
                     gamma: 32'h0400_0000, dist_mode: 1'b0, t_const: 32'sh8000_0000,
                     t_weight: 32'h0300_0000};
            4: c = '{omega: 32'h0010_0000, alpha: 32'h0666_6666, beta: 32'h3333_3333,
                     gamma: 32'h0400_0000, dist_mode: 1'b1, t_const: -32'sh00C0_0000,
                     t_weight: 32'h0300_0000};
            default: c = '0;
        endcase
        return c;
    endfunction

    // Result ready: random bursts, plus long hold-offs on request.
    always @(posedge clk)
    begin : rx_side
        int burst;
        int hold_left;
        int seen_req;
        if (!rst_n)
        begin
            burst = 0;
            hold_left = 0;
            seen_req = 0;
            out_ready <= 1'b0;
        end
        else if (seen_req != long_hold_req)
        begin
            seen_req = long_hold_req;
            hold_left = 3000;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (quiet)
        begin
            out_ready <= 1'b1;
        end
        else if (burst > 0)
        begin
            burst = burst - 1;
        end
        else
        begin
            burst = $urandom_range(15, 1);
            out_ready <= ($urandom_range(2) != 0);
        end
    end

    // Compare each accepted total with the oldest expectation.
    always @(posedge clk)
    begin
        gjrnll_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("unexpected total: neg_loglik %0d status %0d",
                       out_data.neg_loglik, out_data.status);
                fail_count++;
            end
            else
            begin
                want = expected_totals.pop_front();
                if (out_data.neg_loglik !== want.neg_loglik)
                begin
                    $error("neg_loglik: expected %0d, actual %0d",
                           want.neg_loglik, out_data.neg_loglik);
                    fail_count++;
                end
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, out_data.status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int                    sent;
        int                    len;
        gjrnll_pkg::out_item_t none;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        quiet = 1'b0;
        long_hold_req = 0;
        cycle_count = 0;
        none = '0;
        fill_log_tab();
        model_cfg = '0;
        clear_series();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset parameters: zero seed, then a zero variance on the second sample.
        add_row(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h8000_0000, 32'h0000_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h0000_0000, 32'hFFFF_FFFF, 1, 1, 48'd0, gjrnll_pkg::STATUS_NONPOS);
        // Non-positive seed denominator.
        add_row(1, 32'h0100_0000, 32'h0100_0000, 1, 1, 48'd0, gjrnll_pkg::STATUS_NONPOS);
        // Seed overflow saturates; then a two-sample series after it.
        add_row(2, 32'h0100_0000, 32'h0100_0000, 1, 1, 48'd0, gjrnll_pkg::STATUS_SAT);
        add_row(0, 32'hFFFF_0000, 32'hFFFF_FFFF, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h7FFF_FFFF, 32'h0000_0000, 1, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        // Normal density, return and proxy extremes, negative returns.
        add_row(3, 32'h0000_0000, 32'h0100_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'hFF80_0000, 32'h0200_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h8000_0000, 32'h0000_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h0010_0000, 32'h0040_0000, 1, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        // Student-t density.
        add_row(4, 32'h0000_0000, 32'h0000_0000, 1, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'hFE00_0000, 32'h0300_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h7FFF_FFFF, 32'h0080_0000, 0, 0, 48'd0, gjrnll_pkg::STATUS_OK);
        add_row(0, 32'h0000_0001, 32'h0000_0001, 1, 0, 48'd0, gjrnll_pkg::STATUS_OK);

        foreach (rows[i])
        begin
            if (rows[i].cfg_set != 0)
            begin
                in_valid <= 1'b0;
                wait_idle();
                load_params(param_set(rows[i].cfg_set));
            end
            send_sample(rows[i].req, rows[i].typed, rows[i].result);
        end

        // Random series, new parameters every so often.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(5) == 0)
            begin
                in_valid <= 1'b0;
                wait_idle();
                load_params(random_params());
            end
            if (sent > 300 && long_hold_req == 0)
                long_hold_req = 1;
            if (sent > 600 && long_hold_req == 1)
            begin
                // Sender waits for every outstanding total.
                in_valid <= 1'b0;
                while (expected_totals.size() != 0)
                    @(posedge clk);
                long_hold_req = 2;
            end
            quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++)
                send_sample(random_sample(k == len - 1), 1'b0, none);
            sent = sent + len;
        end
        in_valid <= 1'b0;

        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
